// ===== design/smu_pkg.sv =====
`timescale 1ns / 1ps

package smu_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int LANES     = 8;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROWS      = MEM_BYTES / LANES;
  localparam int ROW_W     = ADDR_W - LANE_W;
  localparam int CFG_W     = 17;
  localparam int LEN_W     = 17;
  localparam int BLEN_W    = 4;
  localparam int EFF_W     = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
  localparam logic [CFG_W-1:0] SIZE_LIMIT_RESET = CFG_W'(65536);

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_PUSH  = 3'd2,
    OP_POP   = 3'd3,
    OP_DROP  = 3'd4,
    OP_SETSP = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACCESS,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [BLEN_W-1:0] len;
    logic [63:0]       wdata;
  } mem_req_t;

endpackage

// ===== design/smu_if.sv =====
`timescale 1ns / 1ps

interface smu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] address;
  logic [16:0] length;
  logic [63:0] write_data;

  modport source (output valid, output operation, output address, output length,
                  output write_data, input ready);
  modport sink (input valid, input operation, input address, input length,
                input write_data, output ready);
endinterface

interface smu_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] read_data;
  logic [63:0] stack_pointer;

  modport source (output valid, output ok, output read_data, output stack_pointer,
                  input ready);
  modport sink (input valid, input ok, input read_data, input stack_pointer,
                output ready);
endinterface

// ===== design/smu_lane_ram.sv =====
`timescale 1ns / 1ps

module smu_lane_ram
  import smu_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [ROW_W-1:0] row,
  input  logic [7:0]       wdata,
  output logic [7:0]       rdata
);

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[row] <= wdata;
    end
    if (re) begin
      rdata <= mem[row];
    end
  end

endmodule

// ===== design/smu_mem_array.sv =====
`timescale 1ns / 1ps

module smu_mem_array
  import smu_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [63:0] rdata
);

  logic [7:0]        lane_rd [LANES];
  logic [LANE_W-1:0] base_q;
  logic [BLEN_W-1:0] len_q;

  // Byte i of the access lives in lane (addr + i) mod 8; lanes below the
  // start lane take the next row.
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [LANE_W-1:0] lane_id;
    logic [LANE_W-1:0] off;
    logic [ROW_W-1:0]  row;
    logic              active;

    assign lane_id = LANE_W'(b);
    assign off     = lane_id - req.addr[LANE_W-1:0];
    assign row     = req.addr[ADDR_W-1:LANE_W] +
                     ROW_W'(lane_id < req.addr[LANE_W-1:0]);
    assign active  = BLEN_W'(off) < req.len;

    smu_lane_ram u_ram (
      .clk   (clk),
      .we    (req.wr && active),
      .re    (req.rd && active),
      .row   (row),
      .wdata (req.wdata[8*off +: 8]),
      .rdata (lane_rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      base_q <= req.addr[LANE_W-1:0];
      len_q  <= req.len;
    end
  end

  always_comb begin
    logic [LANE_W-1:0] lane;
    for (int i = 0; i < LANES; i++) begin
      lane = base_q + LANE_W'(i);
      rdata[8*i +: 8] = (BLEN_W'(i) < len_q) ? lane_rd[lane] : 8'h00;
    end
  end

endmodule

// ===== design/checked_stack_memory_unit.sv =====
`timescale 1ns / 1ps

// Guest byte memory with a descending stack pointer.
//
// request  (sink):   one operation per request: read, write, push, pop,
//                    drop or set stack pointer, with address, length and
//                    little-endian write data.
// response (source): ok flag, zero-extended read data, stack pointer after
//                    the operation. Exactly one response per request.
// size_limit_we/size_limit_wdata: writes the in-use memory size; write only
//                    while no request is in flight.
//
// Timing: a request runs through check, access and result states; its
// response is registered as it leaves the result state. The next request
// is accepted only in the idle state after that, so the block takes no
// request before the last one is through, at a pace set by the range check
// and the registered read of the eight byte-lane memories. A response held
// by the receiver does not stop the next request from being accepted; that
// request then waits in its result cycle until the output register frees.
//
// Reset: stack pointer 0, memory size 65536. Memory contents stay undefined
// until written; there is no clearing pass.
module checked_stack_memory_unit
  import smu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  smu_in_if.sink           request,
  smu_out_if.source        response,
  input  logic             size_limit_we,
  input  logic [CFG_W-1:0] size_limit_wdata
);

  state_t state, state_next;

  logic [CFG_W-1:0]  size_limit;
  logic [63:0]       sp;
  logic [2:0]        op_q;
  logic [63:0]       addr_q;
  logic [LEN_W-1:0]  len_q;
  logic [63:0]       wdata_q;

  // check results
  logic              ok_q;
  logic [ADDR_W-1:0] ea_q;
  logic [63:0]       sp_after_q;
  logic              rd_q;

  logic              out_valid;
  logic              out_ok;
  logic [63:0]       out_rdata;
  logic [63:0]       out_sp;

  mem_req_t          mem_req;
  logic [63:0]       mem_rdata;
  logic              out_load;

  // ---------------------------------------------------------------------
  // Range check (CHECK cycle): one wide add and compare.
  // ---------------------------------------------------------------------
  logic [EFF_W-1:0] eff_size;
  logic [63:0]      eff64;
  logic [63:0]      len64;
  logic [63:0]      ea;
  logic [63:0]      end_addr;
  logic             carry;
  logic             len_ok;
  logic             stack_len;
  logic             chk_ok;
  logic [63:0]      sp_after;

  assign eff_size = (EFF_W'(size_limit) > EFF_W'(MEM_BYTES)) ? EFF_W'(MEM_BYTES)
                                                             : EFF_W'(size_limit);
  assign eff64     = 64'(eff_size);
  assign len64     = 64'(len_q);
  assign stack_len = (len_q == LEN_W'(1)) || (len_q == LEN_W'(2)) ||
                     (len_q == LEN_W'(4)) || (len_q == LEN_W'(8));

  always_comb begin
    ea       = sp;
    end_addr = sp;
    carry    = 1'b0;
    len_ok   = 1'b0;
    sp_after = sp;
    chk_ok   = 1'b0;
    case (op_t'(op_q))
      OP_READ, OP_WRITE: begin
        ea                = addr_q;
        {carry, end_addr} = {1'b0, addr_q} + {1'b0, len64};
        len_ok            = len_q <= LEN_W'(8);
      end
      OP_PUSH: begin
        // new SP plus length gives the old SP back; a wrap below zero fails
        ea       = sp - len64;
        end_addr = sp;
        carry    = sp < len64;
        len_ok   = stack_len;
        sp_after = sp - len64;
      end
      OP_POP: begin
        {carry, end_addr} = {1'b0, sp} + {1'b0, len64};
        len_ok            = stack_len;
        sp_after          = end_addr;
      end
      OP_DROP: begin
        {carry, end_addr} = {1'b0, sp} + {1'b0, len64};
        len_ok            = 1'b1;
        sp_after          = end_addr;
      end
      OP_SETSP: begin
        sp_after = addr_q;
      end
      default: begin
      end
    endcase
    if (op_t'(op_q) == OP_SETSP) begin
      chk_ok = 1'b1;
    end else begin
      chk_ok = len_ok && !carry && (end_addr <= eff64);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign out_load = (state == ST_RESULT) && (!out_valid || response.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (request.valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_RESULT;
      ST_RESULT: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request.ready = 1'b0;
    mem_req.rd    = 1'b0;
    mem_req.wr    = 1'b0;
    mem_req.addr  = ea_q;
    mem_req.len   = len_q[BLEN_W-1:0];
    mem_req.wdata = wdata_q;
    unique case (state)
      ST_IDLE: request.ready = 1'b1;
      ST_ACCESS: begin
        mem_req.rd = ok_q && ((op_t'(op_q) == OP_READ) || (op_t'(op_q) == OP_POP));
        mem_req.wr = ok_q && ((op_t'(op_q) == OP_WRITE) || (op_t'(op_q) == OP_PUSH));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      size_limit <= SIZE_LIMIT_RESET;
      sp         <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (size_limit_we) begin
        size_limit <= size_limit_wdata;
      end
      if ((state == ST_ACCESS) && ok_q) begin
        sp <= sp_after_q;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && request.valid) begin
      op_q    <= request.operation;
      addr_q  <= request.address;
      len_q   <= request.length;
      wdata_q <= request.write_data;
    end
    if (state == ST_CHECK) begin
      ok_q       <= chk_ok;
      ea_q       <= ea[ADDR_W-1:0];
      sp_after_q <= sp_after;
    end
    if (state == ST_ACCESS) begin
      rd_q <= mem_req.rd;
    end
    if (out_load) begin
      out_ok    <= ok_q;
      out_rdata <= rd_q ? mem_rdata : 64'd0;
      out_sp    <= sp;
    end
  end

  smu_mem_array u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign response.valid         = out_valid;
  assign response.ok            = out_ok;
  assign response.read_data     = out_rdata;
  assign response.stack_pointer = out_sp;

endmodule

// ===== bench/checked_stack_memory_unit_tb.sv =====
`timescale 1ns / 1ps

module checked_stack_memory_unit_tb
  import smu_pkg::*;
;

  // Operation codes the block leaves unused; they must fail and change nothing.
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off in the last phase
  localparam int SETTLE      = 8;    // settling wait after the last response

  typedef struct {
    logic [2:0]       operation;
    logic [63:0]      address;
    logic [LEN_W-1:0] length;
    logic [63:0]      write_data;
  } mem_op_t;

  typedef struct {
    logic        ok;
    logic [63:0] read_data;
    logic [63:0] stack_pointer;
  } mem_rsp_t;

  // One queued request with the response it must produce.
  typedef struct {
    mem_op_t  op;
    mem_rsp_t rsp;
  } op_job_t;

  // A byte range written successfully; random reads aim at these.
  typedef struct {
    logic [63:0] addr;
    logic [3:0]  len;
  } span_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  smu_in_if  req_if ();
  smu_out_if rsp_if ();

  checked_stack_memory_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .request          (req_if),
    .response         (rsp_if),
    .size_limit_we    (cfg_we),
    .size_limit_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shadow state of the memory unit. Requests are generated in order and the
  // shadow advances with each one, so the expected response is known before
  // the request goes out; the driver hands it to the checker on acceptance.
  // --------------------------------------------------------------------------
  logic [7:0]       mem_img     [MEM_BYTES];
  bit               mem_written [MEM_BYTES];
  logic [63:0]      sp_shadow;
  logic [CFG_W-1:0] size_limit_shadow;

  op_job_t  pending_ops[$];   // requests not yet offered
  mem_rsp_t awaiting_rsp[$];  // responses owed by the block, oldest first
  span_t    written_spans[$];
  mem_rsp_t in_flight_rsp;    // expectation for the request on the bus

  int mismatches;
  int send_gap_pct;
  int recv_gap_pct;
  bit hold_armed;

  // Bytes of guest memory in use: the size register clamped to the physical size.
  function automatic logic [63:0] usable_bytes();
    if (64'(size_limit_shadow) < 64'(MEM_BYTES)) return 64'(size_limit_shadow);
    return 64'(MEM_BYTES);
  endfunction

  // Range check with no wrap past the top of the 64-bit address space.
  function automatic bit span_fits(logic [63:0] a, logic [63:0] n);
    logic [64:0] lim;
    lim = {1'b0, a} + {1'b0, n};
    return lim <= 65'(usable_bytes());
  endfunction

  function automatic bit stack_len_ok(logic [LEN_W-1:0] n);
    return n == 1 || n == 2 || n == 4 || n == 8;
  endfunction

  function automatic bit has_blank(logic [63:0] a, logic [LEN_W-1:0] n);
    logic [63:0] p;
    for (int i = 0; i < n && i < 8; i++) begin
      p = a + 64'(i);
      if (!mem_written[p[ADDR_W-1:0]]) return 1;
    end
    return 0;
  endfunction

  // True when the request would read a byte that was never written.
  function automatic bit reads_blank(mem_op_t o);
    if (o.operation == OP_READ)
      return o.length <= 8 && span_fits(o.address, 64'(o.length)) &&
             has_blank(o.address, o.length);
    if (o.operation == OP_POP)
      return stack_len_ok(o.length) && span_fits(sp_shadow, 64'(o.length)) &&
             has_blank(sp_shadow, o.length);
    return 0;
  endfunction

  function automatic logic [63:0] load_le(logic [63:0] a, logic [LEN_W-1:0] n);
    logic [63:0] v;
    logic [63:0] p;
    v = '0;
    for (int i = 0; i < n && i < 8; i++) begin
      p = a + 64'(i);
      v[8*i +: 8] = mem_img[p[ADDR_W-1:0]];
    end
    return v;
  endfunction

  function automatic void store_le(logic [63:0] a, logic [LEN_W-1:0] n, logic [63:0] d);
    logic [63:0] p;
    for (int i = 0; i < n && i < 8; i++) begin
      p = a + 64'(i);
      mem_img[p[ADDR_W-1:0]]     = d[8*i +: 8];
      mem_written[p[ADDR_W-1:0]] = 1'b1;
    end
  endfunction

  // Executes one request on the shadow state and returns its response.
  function automatic mem_rsp_t execute_mem_op(mem_op_t o);
    mem_rsp_t    r;
    logic [63:0] nsp;
    logic [63:0] n;
    r = '{ok: 1'b0, read_data: '0, stack_pointer: '0};
    n = 64'(o.length);
    case (o.operation)
      OP_READ: begin
        if (o.length <= 8 && span_fits(o.address, n)) begin
          r.read_data = load_le(o.address, o.length);
          r.ok = 1'b1;
        end
      end
      OP_WRITE: begin
        if (o.length <= 8 && span_fits(o.address, n)) begin
          store_le(o.address, o.length, o.write_data);
          r.ok = 1'b1;
        end
      end
      OP_PUSH: begin
        // descending stack: the new top must fit, else SP stays put
        if (stack_len_ok(o.length)) begin
          nsp = sp_shadow - n;
          if (span_fits(nsp, n)) begin
            store_le(nsp, o.length, o.write_data);
            sp_shadow = nsp;
            r.ok = 1'b1;
          end
        end
      end
      OP_POP: begin
        if (stack_len_ok(o.length) && span_fits(sp_shadow, n)) begin
          r.read_data = load_le(sp_shadow, o.length);
          sp_shadow = sp_shadow + n;
          r.ok = 1'b1;
        end
      end
      OP_DROP: begin
        if (span_fits(sp_shadow, n)) begin
          sp_shadow = sp_shadow + n;
          r.ok = 1'b1;
        end
      end
      OP_SETSP: begin
        sp_shadow = o.address;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.stack_pointer = sp_shadow;
    return r;
  endfunction

  // Queues one request. A read or pop that would touch unwritten memory is
  // turned into a write or a drop of the same fields, so it never happens.
  function automatic void queue_op(logic [2:0] code, logic [63:0] a,
                                   logic [LEN_W-1:0] n, logic [63:0] d);
    op_job_t j;
    j.op = '{operation: code, address: a, length: n, write_data: d};
    if (reads_blank(j.op))
      j.op.operation = (j.op.operation == OP_READ) ? OP_WRITE : OP_DROP;
    j.rsp = execute_mem_op(j.op);
    if (j.op.operation == OP_WRITE && j.rsp.ok && n != 0) begin
      written_spans.push_back('{addr: a, len: n[3:0]});
      if (written_spans.size() > 64) void'(written_spans.pop_front());
    end
    pending_ops.push_back(j);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr();
    logic [63:0] top;
    int          r;
    top = usable_bytes();
    r   = $urandom_range(99);
    if (r < 75) return 64'($urandom_range(0, 32'(top)));
    if (r < 85) return top - 64'($urandom_range(0, 9));
    if (r < 92) return rand64();
    return 64'($urandom_range(0, 63));
  endfunction

  // Mostly legal access sizes; sometimes too long, up to 65536.
  function automatic logic [LEN_W-1:0] pick_access_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return LEN_W'($urandom_range(0, 8));
    if (r < 93) return LEN_W'($urandom_range(9, 16));
    if (r < 96) return LEN_W'(65536);
    return LEN_W'($urandom_range(0, 65536));
  endfunction

  function automatic logic [LEN_W-1:0] pick_stack_len();
    int r;
    r = $urandom_range(99);
    if (r < 90) return LEN_W'(1 << $urandom_range(0, 3));
    return LEN_W'($urandom_range(0, 16));
  endfunction

  function automatic void queue_random_op();
    span_t       s;
    logic [63:0] top;
    int          pick;
    int          r;
    top  = usable_bytes();
    pick = $urandom_range(99);
    r    = $urandom_range(99);
    if (pick < 18) begin
      queue_op(OP_WRITE, pick_addr(), pick_access_len(), rand64());
    end else if (pick < 36) begin
      // reads mostly land on data written earlier
      if (written_spans.size() != 0 && r < 75) begin
        s = written_spans[$urandom_range(0, written_spans.size() - 1)];
        queue_op(OP_READ, s.addr, LEN_W'($urandom_range(0, s.len)), rand64());
      end else begin
        queue_op(OP_READ, pick_addr(), pick_access_len(), rand64());
      end
    end else if (pick < 56) begin
      queue_op(OP_PUSH, rand64(), pick_stack_len(), rand64());
    end else if (pick < 74) begin
      queue_op(OP_POP, rand64(), pick_stack_len(), rand64());
    end else if (pick < 82) begin
      queue_op(OP_DROP, rand64(), (r < 85) ? LEN_W'($urandom_range(0, 16)) :
               LEN_W'($urandom_range(0, 65536)), rand64());
    end else if (pick < 90) begin
      // new stack top: mostly inside memory, sometimes anywhere
      if (r < 60)      queue_op(OP_SETSP, 64'($urandom_range(0, 32'(top))), 0, rand64());
      else if (r < 80) queue_op(OP_SETSP, top - 64'($urandom_range(0, 16)), 0, rand64());
      else             queue_op(OP_SETSP, rand64(), LEN_W'($urandom), rand64());
    end else begin
      // noise: any code, any fields
      queue_op(3'($urandom_range(0, 7)), rand64(), LEN_W'($urandom_range(0, 65536)),
               rand64());
    end
  endfunction

  // Sender stops until the block has answered everything it took. Sampled
  // on the falling edge so the driver's rising-edge updates have settled.
  task automatic drain();
    while (pending_ops.size() != 0 || req_if.valid || awaiting_rsp.size() != 0)
      @(negedge clk);
  endtask

  // The size register is only written while the block is idle.
  task automatic write_size_limit(logic [CFG_W-1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_limit_shadow = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("checked_stack_memory_unit_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request driver: valid stays up until the request is taken; between
  // requests the sender may idle at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    op_job_t j;
    logic    next_valid;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      next_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        awaiting_rsp.push_back(in_flight_rsp);
        next_valid = 1'b0;
      end
      if (!next_valid && pending_ops.size() != 0 &&
          $urandom_range(99) >= send_gap_pct) begin
        j = pending_ops.pop_front();
        req_if.operation  <= j.op.operation;
        req_if.address    <= j.op.address;
        req_if.length     <= j.op.length;
        req_if.write_data <= j.op.write_data;
        in_flight_rsp = j.rsp;
        next_valid = 1'b1;
      end
      req_if.valid <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Response ready: random stalls, plus one long hold-off once armed, which
  // backs the block up until it refuses new requests.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    int hold_left;
    bit hold_done;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: each accepted response against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_responses
    mem_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaiting_rsp.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = awaiting_rsp.pop_front();
        if (rsp_if.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp_if.ok);
          mismatches++;
        end
        if (rsp_if.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, rsp_if.read_data);
          mismatches++;
        end
        if (rsp_if.stack_pointer !== want.stack_pointer) begin
          $error("stack_pointer: expected %h, got %h", want.stack_pointer,
                 rsp_if.stack_pointer);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random phases at several memory
  // sizes and idling patterns.
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] sizes [4];
    int               counts [4];

    // known values on every input before the first edge
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_READ;
    req_if.address    = '0;
    req_if.length     = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;
    mismatches        = 0;
    send_gap_pct      = 0;
    recv_gap_pct      = 0;
    hold_armed        = 1'b0;
    sp_shadow         = '0;
    size_limit_shadow = SIZE_LIMIT_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size. Extremes of address, length and
    // data; wrap at both ends of the address space; every operation.
    queue_op(OP_READ,  64'd0, 0, rand64());                      // empty read at bottom
    queue_op(OP_WRITE, 64'd0, 8, '1);
    queue_op(OP_WRITE, 64'(MEM_BYTES - 8), 8, 64'h0123_4567_89ab_cdef);
    queue_op(OP_READ,  64'(MEM_BYTES - 8), 8, '0);               // top eight bytes
    queue_op(OP_READ,  64'd0, 8, '0);
    queue_op(OP_READ,  64'd3, 3, '0);
    queue_op(OP_READ,  64'(MEM_BYTES), 0, '0);                   // empty read at the end
    queue_op(OP_READ,  64'(MEM_BYTES - 4), 5, '0);               // crosses the end
    queue_op(OP_WRITE, 64'd16, 9, rand64());                     // longer than eight
    queue_op(OP_READ,  64'd0, LEN_W'(65536), '0);
    queue_op(OP_READ,  '1, 8, '0);                               // wraps past 2^64
    queue_op(OP_WRITE, '1, 0, rand64());
    queue_op(OP_PUSH,  '0, 1, rand64());                         // SP 0: new SP wraps
    queue_op(OP_SETSP, 64'(MEM_BYTES), 0, '0);
    queue_op(OP_PUSH,  '0, 8, 64'hfedc_ba98_7654_3210);
    queue_op(OP_PUSH,  '0, 4, 64'h0000_0000_a5a5_5a5a);
    queue_op(OP_PUSH,  '0, 2, '1);
    queue_op(OP_PUSH,  '0, 1, 64'h80);
    queue_op(OP_PUSH,  '0, 3, rand64());                         // bad stack length
    queue_op(OP_POP,   '0, 1, '0);
    queue_op(OP_POP,   '0, 2, '0);
    queue_op(OP_POP,   '0, 4, '0);
    queue_op(OP_POP,   '0, 8, '0);
    queue_op(OP_POP,   '0, 8, '0);                               // SP at the end: fails
    queue_op(OP_SETSP, '0, 0, '0);
    queue_op(OP_DROP,  '0, LEN_W'(65536), '0);                   // whole memory
    queue_op(OP_DROP,  '0, 0, '0);
    queue_op(OP_SETSP, '1, 0, '0);
    queue_op(OP_POP,   '0, 1, '0);
    queue_op(OP_DROP,  '0, 1, '0);
    queue_op(OP_UNUSED_A, rand64(), 4, rand64());
    queue_op(OP_UNUSED_B, rand64(), 8, rand64());
    drain();

    // full size, empty memory, a random size, full size again
    sizes[0] = CFG_W'(MEM_BYTES);
    sizes[1] = '0;
    sizes[2] = CFG_W'($urandom_range(64, MEM_BYTES - 1));
    sizes[3] = CFG_W'(MEM_BYTES);
    counts   = '{700, 80, 650, 650};

    for (int ph = 0; ph < 4; ph++) begin
      write_size_limit(sizes[ph]);
      case (ph)
        0, 1: begin send_gap_pct = 23; recv_gap_pct = 50; end
        2:    begin send_gap_pct = 50; recv_gap_pct = 23; end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      // stack somewhere inside memory to start each phase
      queue_op(OP_SETSP, 64'($urandom_range(0, 32'(usable_bytes()))), 0, rand64());
      for (int k = 0; k < counts[ph]; k++) queue_random_op();
      if (ph == 3) hold_armed = 1'b1;
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && awaiting_rsp.size() == 0) begin
      $display("checked_stack_memory_unit_tb: PASS");
    end else begin
      $display("checked_stack_memory_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
